@@ sv/tlvs_pkg.sv @@
// tlvs_pkg: shared types and constants for the tlv stream splitter
// holds the phase encoding, status codes and transaction structs
// no dependencies
`timescale 1ns / 1ps

package tlvs_pkg;

  // tag byte that ends parsing of a packet
  localparam logic [7:0] END_TAG = 8'h00;

  // packet status codes
  localparam logic [1:0] ST_CONT  = 2'd0;
  localparam logic [1:0] ST_OK    = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  // parser phase, one-hot
  typedef enum logic [3:0] {
    PH_TAG  = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_DATA = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  // one input transaction
  typedef struct packed {
    logic       packet_end;
    logic [7:0] in_byte;
  } item_t;

  // one result transaction
  typedef struct packed {
    logic [1:0] packet_status;
    logic       elem_last;
    logic [7:0] byte_offset;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] elem_tag;
  } res_t;

endpackage

@@ sv/tlvs_parser.sv @@
// tlvs_parser: phase and counter state of the tlv parser plus its step logic
// computes one result per registered input byte and updates state on step
// depends on tlvs_pkg
`timescale 1ns / 1ps

module tlvs_parser
  import tlvs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  input  item_t item,
  output res_t  res
);

  phase_t     phase, phase_next;
  logic [7:0] held_tag, held_tag_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] position, position_next;
  logic       fine;

  // step logic for one byte
  always_comb begin
    phase_next      = phase;
    held_tag_next   = held_tag;
    bytes_left_next = bytes_left;
    position_next   = position;
    fine            = 1'b1;
    res             = '0;
    res.packet_status = ST_CONT;

    unique case (phase)
      PH_TAG: begin
        if (item.in_byte == END_TAG) begin
          phase_next = PH_DONE;
        end else begin
          held_tag_next = item.in_byte;
          phase_next    = PH_LEN;
          fine          = 1'b0;
        end
      end
      PH_LEN: begin
        if (item.in_byte == 8'd0) begin
          phase_next = PH_TAG;
        end else begin
          bytes_left_next = item.in_byte;
          position_next   = 8'd0;
          phase_next      = PH_DATA;
          fine            = 1'b0;
        end
      end
      PH_DATA: begin
        res.elem_tag      = held_tag;
        res.payload_byte  = item.in_byte;
        res.payload_valid = 1'b1;
        res.byte_offset   = position;
        res.elem_last     = (bytes_left <= 8'd1);
        position_next     = position + 8'd1;
        if (bytes_left <= 8'd1) begin
          bytes_left_next = 8'd0;
          phase_next      = PH_TAG;
        end else begin
          bytes_left_next = bytes_left - 8'd1;
          fine            = 1'b0;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    // end of packet: report and return to the start state
    if (item.packet_end) begin
      res.packet_status = fine ? ST_OK : ST_TRUNC;
      phase_next        = PH_TAG;
      held_tag_next     = 8'd0;
      bytes_left_next   = 8'd0;
      position_next     = 8'd0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TAG;
      held_tag   <= 8'd0;
      bytes_left <= 8'd0;
      position   <= 8'd0;
    end else if (step) begin
      phase      <= phase_next;
      held_tag   <= held_tag_next;
      bytes_left <= bytes_left_next;
      position   <= position_next;
    end
  end

  // a packet end always leaves the parser ready for a new tag
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    step && item.packet_end |=> phase == PH_TAG && bytes_left == 8'd0)
    else $error("parser state not cleared after packet end");

  // inside a payload at least one byte is still due
  a_data_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> bytes_left != 8'd0)
    else $error("payload phase with no bytes left");

  // the element end mark only comes with a payload byte
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    res.elem_last |-> res.payload_valid)
    else $error("element end without payload byte");

  // after an end tag no payload appears
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE |-> !res.payload_valid)
    else $error("payload after end tag");

endmodule

@@ sv/tlv_stream_splitter.sv @@
// an accepted input transaction goes through the input register, then the result
// register, before its result shows on m_tvalid
// throughput: one byte per cycle while m_tready does not stall the result register
// one result transaction for every input byte, in order
// rst (synchronous, active high) empties both pipeline registers and puts the
// parser back to expecting a tag byte
// depends on tlvs_pkg and tlvs_parser
`timescale 1ns / 1ps

module tlv_stream_splitter
  import tlvs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // packet_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] elem_tag, [15:8] payload_byte, [23:16] byte_offset
  output logic [2:0]  m_tuser,   // [0] payload_valid, [2:1] packet_status
  output logic        m_tlast    // elem_last
);

  logic  in_valid;
  item_t in_item;
  logic  adv;
  res_t  res;
  res_t  out_res;

  // a held byte moves on when the result register is free or draining
  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.in_byte    <= s_tdata;
      in_item.packet_end <= s_tlast;
    end
  end

  tlvs_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (adv),
    .item (in_item),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res;
    end
  end

  // pack the result transaction
  assign m_tdata = {out_res.byte_offset, out_res.payload_byte, out_res.elem_tag};
  assign m_tuser = {out_res.packet_status, out_res.payload_valid};
  assign m_tlast = out_res.elem_last;

endmodule

@@ tb/tb_tlv_stream_splitter.sv @@
// tb_tlv_stream_splitter: self-checking testbench for the tlv stream splitter
// predicts every result transaction from the accepted input bytes and checks it in order
// depends on tlvs_pkg and tlv_stream_splitter
`timescale 1ns / 1ps

module tb_tlv_stream_splitter
  import tlvs_pkg::*;
();

  typedef logic [7:0] byte_q_t[$];

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] in_byte
  logic        s_tlast = 1'b0;    // packet_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;           // [7:0] elem_tag, [15:8] payload_byte, [23:16] byte_offset
  logic [2:0]  m_tuser;           // [0] payload_valid, [2:1] packet_status
  logic        m_tlast;           // elem_last

  // parser state mirrored by the predictor
  phase_t     pr_phase;
  logic [7:0] pr_tag;
  logic [7:0] pr_left;
  logic [7:0] pr_offset;

  res_t expected_q[$];
  int   mismatches = 0;
  int   bytes_sent = 0;
  int   hold_cycles = 0;
  bit   tx_idle = 1'b1;
  bit   rx_idle = 1'b1;
  res_t got;
  res_t want;

  tlv_stream_splitter i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state back to the start of a packet
  task automatic clear_parser();
    pr_phase  = PH_TAG;
    pr_tag    = 8'h00;
    pr_left   = 8'h00;
    pr_offset = 8'h00;
  endtask

  // work out the result of one accepted byte and queue it
  task automatic predict_byte(input logic [7:0] b, input logic last);
    res_t r;
    logic fine;
    r = '0;
    fine = 1'b1;
    case (pr_phase)
      PH_TAG: begin
        if (b == END_TAG) begin
          pr_phase = PH_DONE;
        end else begin
          pr_tag   = b;
          pr_phase = PH_LEN;
          fine     = 1'b0;
        end
      end
      PH_LEN: begin
        // zero length element is skipped
        if (b == 8'd0) begin
          pr_phase = PH_TAG;
        end else begin
          pr_left   = b;
          pr_offset = 8'd0;
          pr_phase  = PH_DATA;
          fine      = 1'b0;
        end
      end
      PH_DATA: begin
        r.elem_tag      = pr_tag;
        r.payload_byte  = b;
        r.payload_valid = 1'b1;
        r.byte_offset   = pr_offset;
        r.elem_last     = (pr_left <= 8'd1);
        pr_offset++;
        if (pr_left <= 8'd1) begin
          pr_left  = 8'd0;
          pr_phase = PH_TAG;
        end else begin
          pr_left--;
          fine = 1'b0;
        end
      end
      default: ;
    endcase
    r.packet_status = ST_CONT;
    if (last) begin
      r.packet_status = fine ? ST_OK : ST_TRUNC;
      clear_parser();
    end
    expected_q = {expected_q, r};
  endtask

  // offer one byte after a random gap and wait for the transaction
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    bit took;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do begin
      @(negedge clk);
      took = s_tready;
      @(posedge clk);
    end while (!took);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_packet(input byte_q_t pkt);
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // stop offering and let every expected result come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // random packet: mostly well formed, some truncated, some noise
  task automatic build_packet(output byte_q_t pkt);
    int n_elem;
    int len;
    int kind;
    pkt = {};
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      len = $urandom_range(1, 12);
      repeat (len) pkt = {pkt, 8'($urandom_range(0, 255))};
      return;
    end
    n_elem = $urandom_range(1, 4);
    repeat (n_elem) begin
      len = ($urandom_range(0, 79) == 0) ? $urandom_range(100, 255) : $urandom_range(0, 8);
      pkt = {pkt, 8'($urandom_range(1, 255))};
      pkt = {pkt, 8'(len)};
      repeat (len) pkt = {pkt, 8'($urandom_range(0, 255))};
    end
    if (kind == 1) begin
      // end tag, then bytes that must be ignored
      pkt = {pkt, END_TAG};
      len = $urandom_range(0, 4);
      repeat (len) pkt = {pkt, 8'($urandom_range(0, 255))};
    end else if (kind <= 3) begin
      len = $urandom_range(1, pkt.size());
      while (pkt.size() > len) void'(pkt.pop_back());
    end
  endtask

  task automatic flag_mismatch(input string what, input res_t exp_r, input res_t act_r);
    mismatches++;
    if (mismatches <= 10) begin
      $write("%0t %s: expected tag=%h byte=%h valid=%b off=%0d last=%b status=%0d,",
             $time, what, exp_r.elem_tag, exp_r.payload_byte, exp_r.payload_valid,
             exp_r.byte_offset, exp_r.elem_last, exp_r.packet_status);
      $display(" got tag=%h byte=%h valid=%b off=%0d last=%b status=%0d",
               act_r.elem_tag, act_r.payload_byte, act_r.payload_valid,
               act_r.byte_offset, act_r.elem_last, act_r.packet_status);
    end
  endtask

  // element boundaries, end tag, zero length and every way a packet can end
  task automatic test_special_cases();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_packet('{8'h01, 8'h03, 8'h00, 8'hFF, 8'h5A});
    send_packet('{END_TAG, 8'hAA, 8'h55});
    send_packet('{8'h07, 8'h00});
    send_packet('{8'h09});
    send_packet('{8'h09, 8'h04});
    send_packet('{8'h03, 8'h04, 8'h11, 8'h22});
    send_packet('{8'hFF, 8'h01, 8'h80, END_TAG});
    send_packet('{8'h04, 8'h00, 8'h05, 8'h01, 8'hC3});
    wait_drained();
  endtask

  // longest element: offsets run up to 254
  task automatic test_longest_element();
    byte_q_t pkt;
    pkt = '{8'hA5, 8'hFF};
    repeat (255) pkt = {pkt, 8'($urandom_range(0, 255))};
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    send_packet(pkt);
    wait_drained();
  endtask

  task automatic test_random_packets(input int n_bytes);
    byte_q_t pkt;
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      build_packet(pkt);
      send_packet(pkt);
    end
    wait_drained();
  endtask

  // receiver holds off for a long stretch while bytes keep coming
  task automatic test_backpressure();
    byte_q_t pkt;
    int stop_at;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_cycles = 200;
    stop_at = bytes_sent + 150;
    while (bytes_sent < stop_at) begin
      build_packet(pkt);
      send_packet(pkt);
    end
    wait_drained();
  endtask

  // receiver: random stalls, plus the long hold when asked
  initial begin
    int stall;
    bit took;
    @(negedge rst);
    forever begin
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      stall = rx_idle ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do begin
        @(negedge clk);
        took = m_tvalid;
        @(posedge clk);
      end while (!took);
    end
  end

  // compare each result transaction with the oldest prediction
  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got.elem_tag      = m_tdata[7:0];
      got.payload_byte  = m_tdata[15:8];
      got.byte_offset   = m_tdata[23:16];
      got.payload_valid = m_tuser[0];
      got.packet_status = m_tuser[2:1];
      got.elem_last     = m_tlast;
      if (expected_q.size() == 0) begin
        flag_mismatch("unexpected result", '0, got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) flag_mismatch("mismatch", want, got);
      end
    end
  end

  // test sequence
  initial begin
    clear_parser();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_special_cases();
    test_longest_element();
    test_random_packets(600);
    test_backpressure();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
